// ===== sv/tea_variant_block_cipher_unit_assert.svh =====
// Assertion macros for the TEA variant block cipher unit.
// Each macro expands to one labeled concurrent assertion.
`ifndef TEA_VARIANT_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define TEA_VARIANT_BLOCK_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TVBC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TVBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tvbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tvbc_pkg
// Types and constants shared by the TEA variant block cipher unit.
// ----------------------------------------------------------------------------
package tvbc_pkg;

   localparam int WordWidth     = 32;
   localparam int CsrIndexWidth = 2;

   localparam logic [WordWidth-1:0] TeaDelta = 32'h9E37_79B9;

   localparam logic [WordWidth-1:0] ResetKeyZero  = 32'h003F_FFEF;
   localparam logic [WordWidth-1:0] ResetKeyOne   = 32'h0000_00E5;
   localparam logic [WordWidth-1:0] ResetKeyTwo   = 32'h3FFF_FFDD;
   localparam logic [WordWidth-1:0] ResetKeyThree = 32'h0000_7FC3;

   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_KEY_ZERO  = 2'd0,
      CSR_KEY_ONE   = 2'd1,
      CSR_KEY_TWO   = 2'd2,
      CSR_KEY_THREE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WordWidth-1:0] key_zero;
      logic [WordWidth-1:0] key_one;
      logic [WordWidth-1:0] key_two;
      logic [WordWidth-1:0] key_three;
   } key_set_type;

   typedef struct packed {
      logic                 vld;
      mode_type             mode;
      logic [WordWidth-1:0] first_word;
      logic [WordWidth-1:0] second_word;
   } stage_type;

endpackage

// ===== sv/tvbc_if.sv =====
// ----------------------------------------------------------------------------
// tvbc_req_if / tvbc_rsp_if
// Valid/ready channels carrying blocks into and out of the cipher unit.
// ----------------------------------------------------------------------------
interface tvbc_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] first_word;
   logic [31:0] second_word;

   modport source (output valid, mode, first_word, second_word, input ready);
   modport sink   (input valid, mode, first_word, second_word, output ready);
endinterface

interface tvbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_first_word;
   logic [31:0] out_second_word;

   modport source (output valid, out_first_word, out_second_word, input ready);
   modport sink   (input valid, out_first_word, out_second_word, output ready);
endinterface

// ===== sv/tea_variant_block_cipher_unit.sv =====
// Each half-round is its own register stage, followed by the output register.
// Throughput: one item per cycle while the skid entry is empty.
// A result stalled at rsp is held while one more item parks in the skid entry.
// Reset (synchronous, active high) empties the pipeline and loads default keys.
// ----------------------------------------------------------------------------
// tea_variant_block_cipher_unit
// TEA variant 64-bit block cipher, encrypt or decrypt per item.
// ----------------------------------------------------------------------------
module tea_variant_block_cipher_unit
   import tvbc_pkg::*;
#(
   parameter int ROUNDS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   tvbc_req_if.sink                 req,
   tvbc_rsp_if.source               rsp,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]     csr_write_data
);

   localparam int NumStages = 2 * ROUNDS;

   key_set_type keys_ff;
   key_set_type keys_in;
   stage_type   stage_q [0:NumStages];
   logic        pipe_en;

   always_comb begin
      keys_in = keys_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_ZERO:  keys_in.key_zero  = csr_write_data;
            CSR_KEY_ONE:   keys_in.key_one   = csr_write_data;
            CSR_KEY_TWO:   keys_in.key_two   = csr_write_data;
            CSR_KEY_THREE: keys_in.key_three = csr_write_data;
            default:       keys_in = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '{key_zero: ResetKeyZero, key_one: ResetKeyOne,
                      key_two: ResetKeyTwo, key_three: ResetKeyThree};
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign req.ready = pipe_en;

   always_comb begin
      stage_q[0].vld         = req.valid;
      stage_q[0].mode        = mode_type'(req.mode);
      stage_q[0].first_word  = req.first_word;
      stage_q[0].second_word = req.second_word;
   end

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      tvbc_round_stage #(
         .ROUNDS (ROUNDS),
         .STAGE  (s)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .keys     (keys_ff),
         .in_data  (stage_q[s]),
         .out_data (stage_q[s+1])
      );
   end

   tvbc_out_buffer u_out (
      .clock           (clock),
      .reset           (reset),
      .last            (stage_q[NumStages]),
      .rsp_ready       (rsp.ready),
      .pipe_en         (pipe_en),
      .rsp_valid       (rsp.valid),
      .rsp_first_word  (rsp.out_first_word),
      .rsp_second_word (rsp.out_second_word)
   );

endmodule

// ===== sv/tvbc_round_stage.sv =====
// ----------------------------------------------------------------------------
// tvbc_round_stage
// One registered half-round. Encrypt updates the first word on even stages,
// decrypt updates the second word on even stages; sums are fixed per stage.
// ----------------------------------------------------------------------------
module tvbc_round_stage
   import tvbc_pkg::*;
#(
   parameter int ROUNDS = 32,
   parameter int STAGE  = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  key_set_type keys,
   input  stage_type   in_data,
   output stage_type   out_data
);

   localparam int RoundIndex = STAGE / 2;
   localparam logic StageOdd = 1'(STAGE % 2);

   localparam logic [63:0] EncProd = (64'(RoundIndex) + 64'd1) * {32'd0, TeaDelta};
   localparam logic [63:0] DecProd = (64'(ROUNDS) - 64'(RoundIndex)) * {32'd0, TeaDelta};
   localparam logic [WordWidth-1:0] SumEnc = EncProd[WordWidth-1:0];
   localparam logic [WordWidth-1:0] SumDec = DecProd[WordWidth-1:0];

   logic                 update_first;
   logic [WordWidth-1:0] operand;
   logic [WordWidth-1:0] key_left;
   logic [WordWidth-1:0] key_right;
   logic [WordWidth-1:0] sum;
   logic [WordWidth-1:0] mix;
   logic [WordWidth-1:0] target;
   logic [WordWidth-1:0] result;
   logic                 vld_ff;
   stage_type            data_ff;
   stage_type            data_in;

   always_comb begin
      update_first = ((in_data.mode == MODE_DECRYPT) == StageOdd);
      operand      = update_first ? in_data.second_word : in_data.first_word;
      key_left     = update_first ? keys.key_two   : keys.key_one;
      key_right    = update_first ? keys.key_three : keys.key_zero;
      sum          = (in_data.mode == MODE_DECRYPT) ? SumDec : SumEnc;
      mix          = ((operand << 4) + key_left) ^ ((operand >> 5) + key_right)
                     ^ (sum + operand);
      target       = update_first ? in_data.first_word : in_data.second_word;
      result       = (in_data.mode == MODE_DECRYPT) ? (target - mix) : (target + mix);

      data_in             = in_data;
      data_in.first_word  = update_first ? result : in_data.first_word;
      data_in.second_word = update_first ? in_data.second_word : result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_data.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      out_data     = data_ff;
      out_data.vld = vld_ff;
   end

endmodule

// ===== sv/tvbc_out_buffer.sv =====
// ----------------------------------------------------------------------------
// tvbc_out_buffer
// Output register plus skid entry. The pipeline keeps moving until the skid
// entry fills, so new items are taken while a result waits.
// ----------------------------------------------------------------------------
module tvbc_out_buffer
   import tvbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  stage_type            last,
   input  logic                 rsp_ready,
   output logic                 pipe_en,
   output logic                 rsp_valid,
   output logic [WordWidth-1:0] rsp_first_word,
   output logic [WordWidth-1:0] rsp_second_word
);

   logic      out_vld_ff;
   logic      out_vld_in;
   logic      skid_vld_ff;
   logic      skid_vld_in;
   stage_type out_ff;
   stage_type out_in;
   stage_type skid_ff;
   stage_type skid_in;
   logic      out_free;
   logic      transfer;

   assign pipe_en  = !skid_vld_ff;
   assign transfer = pipe_en && last.vld;
   assign out_free = !out_vld_ff || rsp_ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = last;
            out_vld_in = transfer;
         end
      end else if (transfer) begin
         // hold the output, park the arriving item
         skid_in     = last;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_first_word  = out_ff.first_word;
   assign rsp_second_word = out_ff.second_word;

endmodule

// ===== sv/tvbc_checker.sv =====
// ----------------------------------------------------------------------------
// tvbc_checker
// Port-level checks on the cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "tea_variant_block_cipher_unit_assert.svh"

module tvbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_first_word,
   input logic [31:0] rsp_out_second_word
);

   `TVBC_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")
   `TVBC_ASSERT_NOW(a_backpressure_cause, clock, reset, !req_ready, $past(rsp_valid && !rsp_ready), "req stalled without rsp stall")
   `TVBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")
   `TVBC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_first_word) && $stable(rsp_out_second_word), "rsp payload changed")

endmodule

bind tea_variant_block_cipher_unit tvbc_checker u_tvbc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_out_first_word  (rsp.out_first_word),
   .rsp_out_second_word (rsp.out_second_word)
);

// ===== bench/tea_variant_block_cipher_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tea_variant_block_cipher_unit_checker
// Watches the request, response and key-write ports of the cipher unit. For
// every accepted request it computes the ciphered block from its own copy of
// the keys and queues it. Every accepted response is compared with the oldest
// queued block. Reports the number of mismatches and the blocks still owed.
// ----------------------------------------------------------------------------
module tea_variant_block_cipher_unit_checker
   import tvbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   tvbc_req_if                      req,
   tvbc_rsp_if                      rsp,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]     csr_write_data,
   output int                       fail_count,
   output int                       outstanding
);

   localparam int CipherRounds = 32;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type first_word;
      word_type second_word;
   } cipher_block_type;

   key_set_type      key_copy;
   cipher_block_type expected_blocks[$];

   function automatic word_type mix_upper(word_type w, word_type total, key_set_type k);
      return ((w << 4) + k.key_two) ^ ((w >> 5) + k.key_three) ^ (total + w);
   endfunction

   function automatic word_type mix_lower(word_type w, word_type total, key_set_type k);
      return ((w >> 5) + k.key_zero) ^ ((w << 4) + k.key_one) ^ (total + w);
   endfunction

   function automatic cipher_block_type cipher_block(mode_type op, word_type a, word_type b,
                                                     key_set_type k);
      word_type         total;
      cipher_block_type blk;
      total = '0;
      if (op == MODE_ENCRYPT) begin
         for (int r = 0; r < CipherRounds; r++) begin
            total = total + TeaDelta;
            a = a + mix_upper(b, total, k);
            b = b + mix_lower(a, total, k);
         end
      end else begin
         for (int r = 0; r < CipherRounds; r++) total = total + TeaDelta;
         for (int r = 0; r < CipherRounds; r++) begin
            b = b - mix_lower(a, total, k);
            a = a - mix_upper(b, total, k);
            total = total - TeaDelta;
         end
      end
      blk.first_word  = a;
      blk.second_word = b;
      return blk;
   endfunction

   always @(posedge clock) begin
      cipher_block_type want;
      if (reset) begin
         key_copy.key_zero  = ResetKeyZero;
         key_copy.key_one   = ResetKeyOne;
         key_copy.key_two   = ResetKeyTwo;
         key_copy.key_three = ResetKeyThree;
         expected_blocks.delete();
         fail_count = 0;
      end else begin
         // predict with the keys in force before this edge
         if (req.valid && req.ready)
            expected_blocks = {expected_blocks,
                               cipher_block(mode_type'(req.mode), req.first_word,
                                            req.second_word, key_copy)};
         if (rsp.valid && rsp.ready) begin
            if (expected_blocks.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got %08h %08h", $time,
                        rsp.out_first_word, rsp.out_second_word);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp.out_first_word !== want.first_word) begin
                  fail_count++;
                  $display("%0t: out_first_word expected %08h, got %08h", $time,
                           want.first_word, rsp.out_first_word);
               end
               if (rsp.out_second_word !== want.second_word) begin
                  fail_count++;
                  $display("%0t: out_second_word expected %08h, got %08h", $time,
                           want.second_word, rsp.out_second_word);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_KEY_ZERO:  key_copy.key_zero  = csr_write_data;
               CSR_KEY_ONE:   key_copy.key_one   = csr_write_data;
               CSR_KEY_TWO:   key_copy.key_two   = csr_write_data;
               CSR_KEY_THREE: key_copy.key_three = csr_write_data;
               default: ;
            endcase
         end
      end
      outstanding = expected_blocks.size();
   end

endmodule

// ===== bench/tea_variant_block_cipher_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tea_variant_block_cipher_unit_tb
// Drives blocks and key writes into the cipher unit under changing back
// pressure. Directed corner blocks run under several key sets, along with
// random blocks; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tea_variant_block_cipher_unit_tb;
   import tvbc_pkg::*;

   localparam int IdleLimit    = 4000;
   localparam int HoldCycles   = 400;
   localparam int SettleCycles = 80;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [WordWidth-1:0]     csr_write_data;
   int                       fail_count;
   int                       outstanding;
   int                       send_idle_pct;
   int                       recv_idle_pct;
   int                       idle_cycles;
   logic                     rsp_hold_active;
   event                     start_rsp_hold;

   tvbc_req_if req_ch ();
   tvbc_rsp_if rsp_ch ();

   tea_variant_block_cipher_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tea_variant_block_cipher_unit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver side: random stalls, or a long hold when asked
   always @(negedge clock) begin
      if (rsp_hold_active) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always begin
      @(start_rsp_hold);
      rsp_hold_active = 1'b1;
      repeat (HoldCycles) @(negedge clock);
      rsp_hold_active = 1'b0;
   end

   // watchdog: cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [WordWidth-1:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer_block(mode_type op, logic [WordWidth-1:0] a, logic [WordWidth-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= op;
      req_ch.first_word  <= a;
      req_ch.second_word <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer_random_blocks(int count);
      for (int n = 0; n < count; n++)
         offer_block(mode_type'($urandom_range(1)), pick_word(), pick_word());
   endtask

   // drop valid and hold until every result is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   task automatic load_keys(logic [WordWidth-1:0] k0, logic [WordWidth-1:0] k1,
                            logic [WordWidth-1:0] k2, logic [WordWidth-1:0] k3);
      logic [WordWidth-1:0] keys[4];
      keys = '{k0, k1, k2, k3};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CsrIndexWidth'(i);
         csr_write_data   <= keys[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic offer_corner_pairs();
      offer_block(MODE_ENCRYPT, '0, '0);
      offer_block(MODE_DECRYPT, '0, '0);
      offer_block(MODE_ENCRYPT, '1, '1);
      offer_block(MODE_DECRYPT, '1, '1);
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_ENCRYPT;
      req_ch.first_word  = '0;
      req_ch.second_word = '0;
      rsp_ch.ready       = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_KEY_ZERO;
      csr_write_data     = '0;
      rsp_hold_active    = 1'b0;
      idle_cycles        = 0;
      send_idle_pct      = 6;
      recv_idle_pct      = 78;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset keys: corner blocks both ways, then random blocks
      offer_corner_pairs();
      offer_block(MODE_ENCRYPT, '0, '1);
      offer_block(MODE_DECRYPT, '1, '0);
      offer_block(MODE_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
      offer_block(MODE_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
      offer_block(MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      offer_block(MODE_DECRYPT, 32'h0000_0001, 32'h8000_0000);
      offer_block(MODE_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
      offer_block(MODE_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF);
      offer_random_blocks(270);
      drain_results();

      load_keys('0, '0, '0, '0);
      offer_corner_pairs();
      drain_results();
      load_keys($urandom, $urandom, $urandom, $urandom);
      send_idle_pct = 78;
      recv_idle_pct = 6;
      offer_random_blocks(270);
      drain_results();

      // no idling; hold the receiver long enough to fill the pipeline
      load_keys('1, '1, '1, '1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      offer_corner_pairs();
      offer_random_blocks(130);
      -> start_rsp_hold;
      offer_random_blocks(140);
      drain_results();

      load_keys('0, '1, '0, '1);
      offer_random_blocks(20);
      drain_results();

      repeat (SettleCycles) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== tea_variant_block_cipher_unit.f =====
+incdir+sv
sv/tvbc_pkg.sv
sv/tvbc_if.sv
sv/tvbc_round_stage.sv
sv/tvbc_out_buffer.sv
sv/tea_variant_block_cipher_unit.sv
sv/tvbc_checker.sv
bench/tea_variant_block_cipher_unit_checker.sv
bench/tea_variant_block_cipher_unit_tb.sv
